FILE: design/lfn_pkg.sv
// ----------------------------------------------------------------------------
// lfn_pkg
// Shared types and constants for the line-follow navigation core.
// ----------------------------------------------------------------------------
package lfn_pkg;

	// Navigation modes; codes six and seven are never entered.
	typedef enum logic [2:0] {
		MODE_START   = 3'd0,
		MODE_FOLLOW  = 3'd1,
		MODE_JFWD    = 3'd2,
		MODE_JTURN   = 3'd3,
		MODE_DEAD    = 3'd4,
		MODE_RECOVER = 3'd5
	} mode_t;

	// Configuration register indexes.
	localparam logic [2:0] CFG_JUNCTION_THR = 3'd0;
	localparam logic [2:0] CFG_DEAD_END_THR = 3'd1;
	localparam logic [2:0] CFG_LINE_DET_THR = 3'd2;
	localparam logic [2:0] CFG_MIN_TURN_MS  = 3'd3;
	localparam logic [2:0] CFG_MAX_TURN_MS  = 3'd4;
	localparam logic [2:0] CFG_CRUISE_SPEED = 3'd5;
	localparam logic [2:0] CFG_TOP_SPEED    = 3'd6;
	localparam logic [2:0] CFG_SPECIAL_SPD  = 3'd7;

	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 48;

	// Timing limits in milliseconds.
	localparam logic [31:0] START_MS     = 32'd2000;
	localparam logic [31:0] JFWD_MS      = 32'd200;
	localparam logic [31:0] MIN_HOLD_MS  = 32'd500;
	localparam logic [31:0] JTURN_MAX_MS = 32'd1500;

	// Fixed wheel speeds.
	localparam logic signed [8:0] SPD_LOST   = 9'sd30;
	localparam logic signed [8:0] SPD_SEARCH = 9'sd40;
	localparam logic signed [8:0] SPD_JFWD   = 9'sd45;

	// Error severity limits on |line_position| in Q8.
	localparam logic [12:0] SEV_EXTREME = 13'd844;
	localparam logic [12:0] SEV_VSHARP  = 13'd716;
	localparam logic [12:0] SEV_SHARP   = 13'd588;
	localparam logic [12:0] SEV_MOD     = 13'd384;

	localparam logic [7:0] MOD_BASE = 8'd58;
	localparam logic [7:0] GENTLE_BAND = 8'd28;
	localparam logic signed [10:0] EXT_LO   = -11'sd90;
	localparam logic signed [10:0] EXT_HI   = 11'sd120;
	localparam logic signed [10:0] VSH_LO   = -11'sd60;
	localparam logic signed [10:0] SHP_LO   = -11'sd30;
	localparam logic signed [10:0] WHEEL_MAX = 11'sd255;
	localparam logic signed [10:0] WHEEL_MIN = -11'sd255;

	typedef struct packed {
		logic [3:0]  junction_thr;
		logic [7:0]  dead_end_thr;
		logic [3:0]  line_det_thr;
		logic [15:0] min_turn_ms;
		logic [15:0] max_turn_ms;
		logic [7:0]  cruise_speed;
		logic [7:0]  top_speed;
		logic [47:0] special_speeds;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] steer_control;
		logic signed [11:0] line_position;
		logic [3:0]         black_count;
		logic [31:0]        now_ms;
	} item_t;

	typedef struct packed {
		mode_t              nav_mode;
		logic               pid_reset;
		logic signed [8:0]  right_speed;
		logic signed [8:0]  left_speed;
		logic               motor_update;
	} result_t;

	// Byte k of the packed special speed register.
	function automatic logic [7:0] spd_byte(input logic [47:0] spd, input int k);
		return spd[8*k +: 8];
	endfunction

endpackage

FILE: design/lfn_cfg.sv
// ----------------------------------------------------------------------------
// lfn_cfg
// Configuration register file with its reset values.
// ----------------------------------------------------------------------------
module lfn_cfg
	import lfn_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Each register takes the low bits of the write data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.junction_thr   <= 4'd4;
			cfg_q.dead_end_thr   <= 8'd20;
			cfg_q.line_det_thr   <= 4'd2;
			cfg_q.min_turn_ms    <= 16'd300;
			cfg_q.max_turn_ms    <= 16'd3000;
			cfg_q.cruise_speed   <= 8'd70;
			cfg_q.top_speed      <= 8'd150;
			cfg_q.special_speeds <= 48'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_JUNCTION_THR: cfg_q.junction_thr   <= cfg_data[3:0];
				CFG_DEAD_END_THR: cfg_q.dead_end_thr   <= cfg_data[7:0];
				CFG_LINE_DET_THR: cfg_q.line_det_thr   <= cfg_data[3:0];
				CFG_MIN_TURN_MS:  cfg_q.min_turn_ms    <= cfg_data[15:0];
				CFG_MAX_TURN_MS:  cfg_q.max_turn_ms    <= cfg_data[15:0];
				CFG_CRUISE_SPEED: cfg_q.cruise_speed   <= cfg_data[7:0];
				CFG_TOP_SPEED:    cfg_q.top_speed      <= cfg_data[7:0];
				CFG_SPECIAL_SPD:  cfg_q.special_speeds <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/lfn_follow.sv
// ----------------------------------------------------------------------------
// lfn_follow
// Wheel speeds while following: severity base speed, steering and clamps.
// ----------------------------------------------------------------------------
module lfn_follow
	import lfn_pkg::*;
(
	input  cfg_t                cfg,
	input  logic [3:0]          black_count,
	input  logic signed [11:0]  line_position,
	input  logic signed [15:0]  steer_control,
	output logic signed [8:0]   left_speed,
	output logic signed [8:0]   right_speed
);

	logic [12:0]        err_abs;
	logic               ext, vsh, shp, mdr;
	logic [7:0]         base;
	logic signed [10:0] lo, hi;
	logic signed [17:0] base_q8, ctl_ext, sum_l, sum_r;
	logic signed [10:0] whl_l, whl_r;

	// Truncating divide by 256, then severity clamp, then the wheel range.
	function automatic logic signed [8:0] wheel(input logic signed [17:0] v,
			input logic signed [10:0] lo_v, input logic signed [10:0] hi_v);
		logic signed [10:0] q;
		logic signed [10:0] c;
		q = {v[17], v[17:8]} + $signed({10'd0, v[17] & (|v[7:0])});
		c = (q < lo_v) ? lo_v : ((q > hi_v) ? hi_v : q);
		c = (c < WHEEL_MIN) ? WHEEL_MIN : ((c > WHEEL_MAX) ? WHEEL_MAX : c);
		return c[8:0];
	endfunction

	// Severity of the line error.
	always_comb begin
		err_abs = line_position[11] ? 13'(-$signed({line_position[11], line_position}))
			: {1'b0, line_position};
		ext = (err_abs > SEV_EXTREME) && (black_count == 4'd1);
		vsh = (err_abs > SEV_VSHARP) && (black_count <= 4'd2);
		shp = err_abs > SEV_SHARP;
		mdr = err_abs > SEV_MOD;
	end

	// Base speed and clamp window for that severity.
	always_comb begin
		if (ext) begin
			base = spd_byte(cfg.special_speeds, 3);
			lo = EXT_LO;
			hi = EXT_HI;
		end else if (vsh) begin
			base = spd_byte(cfg.special_speeds, 4);
			lo = VSH_LO;
			hi = $signed({3'b000, cfg.top_speed});
		end else if (shp) begin
			base = spd_byte(cfg.special_speeds, 5);
			lo = SHP_LO;
			hi = $signed({3'b000, cfg.top_speed});
		end else if (mdr) begin
			base = MOD_BASE;
			lo = '0;
			hi = $signed({3'b000, cfg.top_speed});
		end else begin
			base = cfg.cruise_speed;
			lo = $signed({3'b000, cfg.cruise_speed}) - $signed({3'b000, GENTLE_BAND});
			hi = $signed({3'b000, cfg.cruise_speed}) + $signed({3'b000, GENTLE_BAND});
		end
	end

	// Steering around the base speed.
	always_comb begin
		base_q8 = $signed({2'b00, base, 8'h00});
		ctl_ext = {{2{steer_control[15]}}, steer_control};
		sum_l = base_q8 - ctl_ext;
		sum_r = base_q8 + ctl_ext;
		whl_l = 11'(wheel(sum_l, lo, hi));
		whl_r = 11'(wheel(sum_r, lo, hi));
		left_speed = whl_l[8:0];
		right_speed = whl_r[8:0];
	end

endmodule

FILE: design/lfn_nav.sv
// ----------------------------------------------------------------------------
// lfn_nav
// Navigation state machine: mode, entry time, lost-line count and flags.
// ----------------------------------------------------------------------------
module lfn_nav
	import lfn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  cfg_t    cfg,
	input  item_t   item,
	output result_t res
);

	mode_t       mode_q, mode_d;
	logic [31:0] entry_q, entry_d;
	logic [7:0]  lost_q, lost_d;
	logic        had_q, had_d;
	logic        jseen_q, jseen_d;

	logic [31:0] elapsed;
	logic        on_line, jct_enter, blk_zero, blk_part;
	logic [7:0]  lost_p;
	logic        had_p, jseen_p;
	logic        rec_done;
	logic [7:0]  b_start, b_jturn, b_recov;
	logic signed [8:0] fl_l, fl_r;

	lfn_follow u_follow (
		.cfg           (cfg),
		.black_count   (item.black_count),
		.line_position (item.line_position),
		.steer_control (item.steer_control),
		.left_speed    (fl_l),
		.right_speed   (fl_r)
	);

	// Common terms and the line bookkeeping done while following.
	always_comb begin
		elapsed = item.now_ms - entry_q;
		on_line = (item.black_count >= 4'd2) && (item.black_count < cfg.junction_thr);
		blk_zero = item.black_count == 4'd0;
		blk_part = !blk_zero && (item.black_count < cfg.junction_thr);
		jct_enter = (mode_q == MODE_FOLLOW) && (item.black_count >= cfg.junction_thr)
			&& !jseen_q;
		rec_done = ((elapsed > {16'd0, cfg.min_turn_ms})
			&& (item.black_count >= cfg.line_det_thr))
			|| (elapsed > {16'd0, cfg.max_turn_ms});
		b_start = spd_byte(cfg.special_speeds, 0);
		b_jturn = spd_byte(cfg.special_speeds, 1);
		b_recov = spd_byte(cfg.special_speeds, 2);
		lost_p = lost_q;
		had_p = had_q;
		jseen_p = jseen_q;
		if (mode_q == MODE_FOLLOW) begin
			if (on_line) begin
				had_p = 1'b1;
				lost_p = '0;
				jseen_p = 1'b0;
			end else if (blk_zero && had_q && (lost_q != 8'hFF)) begin
				lost_p = lost_q + 8'd1;
			end
		end
	end

	// Next state.
	always_comb begin
		mode_d = mode_q;
		entry_d = entry_q;
		lost_d = lost_p;
		had_d = had_p;
		jseen_d = jseen_p;
		if (jct_enter) begin
			mode_d = MODE_JFWD;
			entry_d = item.now_ms;
			jseen_d = 1'b1;
			lost_d = '0;
			had_d = had_q;
		end else begin
			unique case (mode_q)
				MODE_START: begin
					if (elapsed >= START_MS) begin
						mode_d = MODE_FOLLOW;
						had_d = 1'b0;
						lost_d = '0;
					end
				end
				MODE_FOLLOW: begin
					if (blk_zero && had_p && !jseen_p) begin
						if (lost_p >= cfg.dead_end_thr) begin
							mode_d = MODE_DEAD;
							entry_d = item.now_ms;
						end
					end else if (blk_part) begin
						lost_d = '0;
					end
				end
				MODE_JFWD: begin
					if (elapsed >= JFWD_MS) begin
						mode_d = MODE_JTURN;
						entry_d = item.now_ms;
					end
				end
				MODE_JTURN: begin
					if ((elapsed >= MIN_HOLD_MS) && on_line) begin
						mode_d = MODE_FOLLOW;
						had_d = 1'b1;
						lost_d = '0;
						jseen_d = 1'b0;
					end else if (elapsed > JTURN_MAX_MS) begin
						mode_d = MODE_FOLLOW;
						had_d = 1'b0;
						jseen_d = 1'b0;
					end
				end
				MODE_DEAD: begin
					if (elapsed >= MIN_HOLD_MS) begin
						mode_d = MODE_RECOVER;
						entry_d = item.now_ms;
					end
				end
				MODE_RECOVER: begin
					if (rec_done) begin
						mode_d = MODE_FOLLOW;
						had_d = 1'b1;
						lost_d = '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Wheel commands and the PID clear pulse.
	always_comb begin
		res = '0;
		res.nav_mode = mode_d;
		if (!jct_enter) begin
			unique case (mode_q)
				MODE_START: begin
					if (elapsed < START_MS) begin
						res.motor_update = 1'b1;
						res.left_speed = $signed({1'b0, b_start});
						res.right_speed = $signed({1'b0, b_start});
					end
				end
				MODE_FOLLOW: begin
					if (blk_zero && had_p && !jseen_p) begin
						res.motor_update = 1'b1;
						if (lost_p < cfg.dead_end_thr) begin
							res.left_speed = SPD_LOST;
							res.right_speed = SPD_LOST;
						end
					end else if (blk_part) begin
						res.motor_update = 1'b1;
						res.left_speed = fl_l;
						res.right_speed = fl_r;
					end else if (blk_zero) begin
						res.motor_update = 1'b1;
						res.left_speed = SPD_SEARCH;
						res.right_speed = SPD_SEARCH;
					end
				end
				MODE_JFWD: begin
					if (elapsed < JFWD_MS) begin
						res.motor_update = 1'b1;
						res.left_speed = SPD_JFWD;
						res.right_speed = SPD_JFWD;
					end else begin
						res.pid_reset = 1'b1;
					end
				end
				MODE_JTURN: begin
					if (!((elapsed >= MIN_HOLD_MS) && on_line) && !(elapsed > JTURN_MAX_MS))
					begin
						res.motor_update = 1'b1;
						res.left_speed = 9'sd0 - $signed({1'b0, b_jturn});
						res.right_speed = $signed({1'b0, b_jturn});
					end
				end
				MODE_DEAD: begin
					res.motor_update = 1'b1;
					res.pid_reset = elapsed >= MIN_HOLD_MS;
				end
				MODE_RECOVER: begin
					if (!rec_done) begin
						res.motor_update = 1'b1;
						res.left_speed = 9'sd0 - $signed({1'b0, b_recov});
						res.right_speed = $signed({1'b0, b_recov});
					end
				end
				default: ;
			endcase
		end
	end

	// State registers advance once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			entry_q <= '0;
			lost_q <= '0;
			had_q <= 1'b0;
			jseen_q <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			entry_q <= entry_d;
			lost_q <= lost_d;
			had_q <= had_d;
			jseen_q <= jseen_d;
		end
	end

endmodule

FILE: design/line_follow_navigation_fsm_core.sv
// ----------------------------------------------------------------------------
// line_follow_navigation_fsm_core
// Line-follow navigation machine, one control tick in, one command out.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one control tick: timestamp, black
// sensor count, line position and the external PID output. Each tick gives
// exactly one request on the master stream with the wheel commands, the
// update flag, the PID clear pulse and the mode after the tick.
// A tick is held in an input register; the navigation logic works on it
// combinationally and its result is written to the output register while the
// machine state advances. m_tvalid rises when the result is registered in
// the output register, which takes it once that register is free, and one
// tick can be accepted every cycle while the receiver takes each result.
// When the receiver stalls, the output register holds its result and the
// input register takes one more tick; after that s_tready falls until the
// result is taken.
// Reset clears both registers' valid flags, puts the machine in startup mode
// with a zero entry time and loads the configuration defaults. The user must
// write configuration via cfg_we, cfg_index, cfg_data only in idle; unchecked.
// ----------------------------------------------------------------------------
module line_follow_navigation_fsm_core
	import lfn_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// now_ms[31:0], black_count[35:32], line_position[47:36], steer_control[63:48]
	input  logic [63:0]          s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// motor_update[0], left_speed[9:1], right_speed[18:10], pid_reset[19],
	// nav_mode[22:20], zero pad[23]
	output logic [23:0]          m_tdata,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    valid_q;
	logic    advance;

	lfn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lfn_nav u_nav (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (res)
	);

	// The held tick moves on whenever the output register is free.
	assign advance = valid_s1 && (!valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= s_tdata;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {1'b0, res_q};

endmodule
